[hdl/energy_meter_frame_parser_defines.svh]
// Assertion macros used by the energy meter frame parser top level.
`ifndef ENERGY_METER_FRAME_PARSER_DEFINES_SVH
`define ENERGY_METER_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH
`define EMFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("emfp assertion failed");
`define EMFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("emfp assertion failed");
`else
`define EMFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define EMFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/emfp_pkg.sv]
// Types, constants and helper functions of the energy meter frame parser.
`timescale 1ns / 1ps

package emfp_pkg;

  localparam int unsigned FrameLen = 35;
  localparam int unsigned IdxW = 6;
  localparam int unsigned FieldW = 24;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);
  localparam logic [7:0] SumSeed = 8'h58;

  localparam logic [IdxW-1:0] OfsCurrent = IdxW'(4);
  localparam logic [IdxW-1:0] OfsVoltage = IdxW'(10);
  localparam logic [IdxW-1:0] OfsPower = IdxW'(16);
  localparam logic [IdxW-1:0] OfsPulses = IdxW'(22);
  localparam logic [IdxW-1:0] OfsTemp = IdxW'(28);

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_CSUM  = 2'd2
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } command_e;

  typedef struct packed {
    command_e   command;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_e           status;
    logic [FieldW-1:0] current_raw;
    logic [FieldW-1:0] voltage_raw;
    logic [FieldW-1:0] power_raw;
    logic [FieldW-1:0] energy_pulses;
    logic [FieldW-1:0] temperature_raw;
  } result_t;

  // Places a byte into a little-endian 24-bit field when the index hits it.
  function automatic logic [FieldW-1:0] latch_field(input logic [FieldW-1:0] field,
                                                    input logic [IdxW-1:0] base,
                                                    input logic [IdxW-1:0] idx,
                                                    input logic [7:0] b);
    logic [FieldW-1:0] f;
    f = field;
    if (idx == base) begin
      f[7:0] = b;
    end else if (idx == base + IdxW'(1)) begin
      f[15:8] = b;
    end else if (idx == base + IdxW'(2)) begin
      f[23:16] = b;
    end
    return f;
  endfunction

endpackage

[hdl/emfp_in_reg.sv]
// Input register stage holding one accepted transaction for the parser core.
`timescale 1ns / 1ps

module emfp_in_reg
  import emfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  down_ready_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  assign ready_o = !valid_q || down_ready_i;
  assign load = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d = item_i;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o = item_q;

endmodule

[hdl/emfp_core.sv]
// Frame state of the parser: byte index, running sum, latched fields and result.
`timescale 1ns / 1ps

module emfp_core
  import emfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        sum_q, sum_d;
  logic [FieldW-1:0] cur_q, cur_d;
  logic [FieldW-1:0] volt_q, volt_d;
  logic [FieldW-1:0] pwr_q, pwr_d;
  logic [FieldW-1:0] pul_q, pul_d;
  logic [FieldW-1:0] temp_q, temp_d;

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    cur_d = cur_q;
    volt_d = volt_q;
    pwr_d = pwr_q;
    pul_d = pul_q;
    temp_d = temp_q;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.status = STATUS_OK;
    if (fire_i) begin
      if (item_i.command == CMD_END) begin
        res_valid_o = 1'b1;
        res_o.status = STATUS_SHORT;
        idx_d = '0;
        sum_d = SumSeed;
      end else if (idx_q >= LastIdx) begin
        res_valid_o = 1'b1;
        res_o.status = (item_i.rx_byte == ~sum_q) ? STATUS_OK : STATUS_CSUM;
        res_o.current_raw = cur_q;
        res_o.voltage_raw = volt_q;
        res_o.power_raw = pwr_q;
        res_o.energy_pulses = pul_q;
        res_o.temperature_raw = temp_q;
        idx_d = '0;
        sum_d = SumSeed;
      end else begin
        sum_d = sum_q + item_i.rx_byte;
        cur_d = latch_field(cur_q, OfsCurrent, idx_q, item_i.rx_byte);
        volt_d = latch_field(volt_q, OfsVoltage, idx_q, item_i.rx_byte);
        pwr_d = latch_field(pwr_q, OfsPower, idx_q, item_i.rx_byte);
        pul_d = latch_field(pul_q, OfsPulses, idx_q, item_i.rx_byte);
        temp_d = latch_field(temp_q, OfsTemp, idx_q, item_i.rx_byte);
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= SumSeed;
      cur_q <= '0;
      volt_q <= '0;
      pwr_q <= '0;
      pul_q <= '0;
      temp_q <= '0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      cur_q <= cur_d;
      volt_q <= volt_d;
      pwr_q <= pwr_d;
      pul_q <= pul_d;
      temp_q <= temp_d;
    end
  end

endmodule

[hdl/emfp_out_reg.sv]
// Result register that holds one result transaction until the consumer takes it.
`timescale 1ns / 1ps

module emfp_out_reg
  import emfp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    stage_ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign stage_ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d = res_q;
    if (stage_ready_o) begin
      valid_d = res_valid_i;
      if (res_valid_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o = res_q;

endmodule

[hdl/energy_meter_frame_parser.sv]
// Top level of the energy meter frame parser.
//
//   Channel  Handshake                  Payload
//   input    in_valid_i / in_ready_o    command_i, rx_byte_i
//   output   out_valid_o / out_ready_i  status_o, current_raw_o, voltage_raw_o,
//                                       power_raw_o, energy_pulses_o, temperature_raw_o
//
// One input transaction is taken per cycle while in_ready_o is high and loads the input
// register; the result register loads a result when the core takes a frame-ending item.
// Reset returns the byte index to zero, the running sum to 0x58 and clears both stages.
// A held result stalls the core, and the input register then fills and drops in_ready_o.
`timescale 1ns / 1ps
`include "energy_meter_frame_parser_defines.svh"

module energy_meter_frame_parser
  import emfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [23:0] current_raw_o,
  output logic [23:0] voltage_raw_o,
  output logic [23:0] power_raw_o,
  output logic [23:0] energy_pulses_o,
  output logic [23:0] temperature_raw_o
);

  item_t   in_item;
  item_t   core_item;
  logic    core_valid;
  logic    stage_ready;
  logic    core_fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.command = command_e'(command_i);
  assign in_item.rx_byte = rx_byte_i;

  emfp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .item_i       (in_item),
    .down_ready_i (stage_ready),
    .valid_o      (core_valid),
    .item_o       (core_item)
  );

  assign core_fire = core_valid && stage_ready;

  emfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (core_fire),
    .item_i      (core_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  emfp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_i         (res),
    .stage_ready_o (stage_ready),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .res_o         (out_res)
  );

  assign status_o = out_res.status;
  assign current_raw_o = out_res.current_raw;
  assign voltage_raw_o = out_res.voltage_raw;
  assign power_raw_o = out_res.power_raw;
  assign energy_pulses_o = out_res.energy_pulses;
  assign temperature_raw_o = out_res.temperature_raw;

  `EMFP_ASSERT_NOW(a_short_zero, clk_i, rst_ni, out_valid_o && status_o == STATUS_SHORT, current_raw_o == '0 && voltage_raw_o == '0 && power_raw_o == '0 && energy_pulses_o == '0 && temperature_raw_o == '0)
  `EMFP_ASSERT_NOW(a_hold_stalls, clk_i, rst_ni, out_valid_o && !out_ready_i, !core_fire)
  `EMFP_ASSERT_NEXT(a_cmd_result, clk_i, rst_ni, core_fire && core_item.command == CMD_END, out_valid_o && status_o == STATUS_SHORT)

endmodule

[tb/sv/tb_energy_meter_frame_parser.sv]
// Self-checking testbench that drives reply frames and checks every parsed result.
`timescale 1ns / 1ps

module tb_energy_meter_frame_parser;
  import emfp_pkg::*;

  typedef struct {
    item_t item;
    bit    drain;
    bit    calm;
  } rx_txn_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = 1'b0;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [23:0] current_raw_o;
  logic [23:0] voltage_raw_o;
  logic [23:0] power_raw_o;
  logic [23:0] energy_pulses_o;
  logic [23:0] temperature_raw_o;

  rx_txn_t pending_q[$];
  result_t reading_q[$];

  logic [IdxW-1:0]   frame_pos = '0;
  logic [7:0]        frame_sum = SumSeed;
  logic [FieldW-1:0] cur_acc = '0;
  logic [FieldW-1:0] volt_acc = '0;
  logic [FieldW-1:0] pwr_acc = '0;
  logic [FieldW-1:0] pulse_acc = '0;
  logic [FieldW-1:0] temp_acc = '0;

  int  fail_count = 0;
  int  queued_items = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  quiet_phase = 1'b0;
  bit  drain_next = 1'b0;

  energy_meter_frame_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .current_raw_o     (current_raw_o),
    .voltage_raw_o     (voltage_raw_o),
    .power_raw_o       (power_raw_o),
    .energy_pulses_o   (energy_pulses_o),
    .temperature_raw_o (temperature_raw_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [FieldW-1:0] place_byte(input logic [FieldW-1:0] field,
                                                   input logic [IdxW-1:0] base,
                                                   input logic [IdxW-1:0] pos,
                                                   input logic [7:0] b);
    logic [FieldW-1:0] f;
    f = field;
    if (pos >= base && pos < base + IdxW'(3)) begin
      f[(pos - base) * 8 +: 8] = b;
    end
    return f;
  endfunction

  task automatic predict_reading(input command_e cmd, input logic [7:0] b);
    result_t r;
    if (cmd == CMD_END) begin
      r.status = STATUS_SHORT;
      r.current_raw = '0;
      r.voltage_raw = '0;
      r.power_raw = '0;
      r.energy_pulses = '0;
      r.temperature_raw = '0;
      reading_q.push_back(r);
      frame_pos = '0;
      frame_sum = SumSeed;
    end else if (frame_pos >= LastIdx) begin
      r.status = (b == ~frame_sum) ? STATUS_OK : STATUS_CSUM;
      r.current_raw = cur_acc;
      r.voltage_raw = volt_acc;
      r.power_raw = pwr_acc;
      r.energy_pulses = pulse_acc;
      r.temperature_raw = temp_acc;
      reading_q.push_back(r);
      frame_pos = '0;
      frame_sum = SumSeed;
    end else begin
      frame_sum = frame_sum + b;
      cur_acc = place_byte(cur_acc, OfsCurrent, frame_pos, b);
      volt_acc = place_byte(volt_acc, OfsVoltage, frame_pos, b);
      pwr_acc = place_byte(pwr_acc, OfsPower, frame_pos, b);
      pulse_acc = place_byte(pulse_acc, OfsPulses, frame_pos, b);
      temp_acc = place_byte(temp_acc, OfsTemp, frame_pos, b);
      frame_pos = frame_pos + IdxW'(1);
    end
  endtask

  task automatic queue_item(input command_e cmd, input logic [7:0] b);
    rx_txn_t t;
    t.item.command = cmd;
    t.item.rx_byte = b;
    t.drain = drain_next;
    t.calm = (queued_items >= 1500);
    drain_next = 1'b0;
    pending_q.push_back(t);
    queued_items++;
  endtask

  // Pattern 0 is random bytes, 1 all zeros, 2 all ones, 3 a random mix of both.
  task automatic queue_frame(input int len, input int pattern, input bit bad_sum);
    logic [7:0] s;
    logic [7:0] b;
    s = SumSeed;
    for (int i = 0; i < len && i < FrameLen - 1; i++) begin
      case (pattern)
        1: b = 8'h00;
        2: b = 8'hFF;
        3: b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: b = 8'($urandom);
      endcase
      s = s + b;
      queue_item(CMD_BYTE, b);
    end
    if (len >= FrameLen) begin
      b = ~s;
      if (bad_sum) begin
        b = b ^ 8'($urandom_range(1, 255));
      end
      queue_item(CMD_BYTE, b);
    end else begin
      queue_item(CMD_END, 8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp_v,
                             input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    rx_txn_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_reading(command_e'(command_i), rx_byte_i);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && reading_q.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        in_valid_i <= 1'b1;
        command_i <= nxt.item.command;
        rx_byte_i <= nxt.item.rx_byte;
        if (nxt.calm) begin
          quiet_phase = 1'b1;
        end
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 9);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d",
                   $time, status_o);
          fail_count++;
        end else begin
          exp_r = reading_q.pop_front();
          check_field("status", 24'(exp_r.status), 24'(status_o));
          check_field("current_raw", exp_r.current_raw, current_raw_o);
          check_field("voltage_raw", exp_r.voltage_raw, voltage_raw_o);
          check_field("power_raw", exp_r.power_raw, power_raw_o);
          check_field("energy_pulses", exp_r.energy_pulses, energy_pulses_o);
          check_field("temperature_raw", exp_r.temperature_raw, temperature_raw_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
    end
  end

  initial begin
    int sel;
    queue_item(CMD_END, 8'h00);
    queue_item(CMD_END, 8'hFF);
    queue_item(CMD_BYTE, 8'h00);
    queue_item(CMD_BYTE, 8'hFF);
    queue_item(CMD_END, 8'hA5);
    for (int i = 0; i < 7; i++) begin
      queue_item(CMD_BYTE, 8'hFF);
    end
    queue_item(CMD_END, 8'h5A);
    queue_item(CMD_BYTE, 8'h58);
    queue_item(CMD_END, 8'h00);

    drain_next = 1'b1;
    queue_frame(FrameLen, 2, 1'b0);
    queue_frame(FrameLen, 1, 1'b0);
    queue_frame(FrameLen, 2, 1'b1);
    queue_item(CMD_END, 8'h00);
    queue_frame(FrameLen - 1, 0, 1'b0);
    while (queued_items < 1650) begin
      if (queued_items > 800 && queued_items < 840) begin
        drain_next = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        queue_frame(FrameLen, $urandom_range(0, 7) < 5 ? 0 : $urandom_range(1, 3), 1'b0);
      end else if (sel == 6) begin
        queue_frame(FrameLen, 0, 1'b1);
      end else if (sel == 7) begin
        queue_frame($urandom_range(0, FrameLen - 1), 0, 1'b0);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          queue_item($urandom_range(0, 3) == 0 ? CMD_END : CMD_BYTE, 8'($urandom));
        end
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[energy_meter_frame_parser] OK");
    end else begin
      $display("[energy_meter_frame_parser] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[energy_meter_frame_parser] ERROR");
    $finish;
  end

endmodule
